// ===== rtl/pen_to_absolute_pointer_mapper_core_defines.svh =====
// ---------------------------------------------------------------------------
// Pen to absolute pointer mapper: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PEN_TO_ABSOLUTE_POINTER_MAPPER_CORE_DEFINES_SVH
`define PEN_TO_ABSOLUTE_POINTER_MAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define PTAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptam: same-cycle check failed");

// next-cycle implication
`define PTAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptam: next-cycle check failed");

`endif

// ===== rtl/ptam_pkg.sv =====
// ---------------------------------------------------------------------------
// Pen to absolute pointer mapper: package
// Field widths, operation and event codes, register map and state types.
// ---------------------------------------------------------------------------
package ptam_pkg;

	localparam int OP_W    = 3;
	localparam int KIND_W  = 2;
	localparam int COORD_W = 16;
	localparam int SIZE_W  = 16;
	localparam int ABS_W   = 16;
	localparam int IDX_W   = 3;
	localparam int NUM_REGS = 8;

	typedef enum logic [OP_W-1:0] {
		OP_PROX_IN  = 3'd0,
		OP_MOVE     = 3'd1,
		OP_DOWN     = 3'd2,
		OP_UP       = 3'd3,
		OP_PROX_OUT = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MOVE    = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TABLET_WIDTH   = 3'd0,
		REG_TABLET_HEIGHT  = 3'd1,
		REG_MON_X_OFFSET   = 3'd2,
		REG_MON_Y_OFFSET   = 3'd3,
		REG_MON_WIDTH      = 3'd4,
		REG_MON_HEIGHT     = 3'd5,
		REG_DESKTOP_WIDTH  = 3'd6,
		REG_DESKTOP_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam logic [SIZE_W-1:0] CFG_RESET [NUM_REGS] = '{
		16'd1920, 16'd1080, 16'd0, 16'd0, 16'd1920, 16'd1080, 16'd1920, 16'd1080
	};

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_CALC,
		CTL_DONE
	} ctl_state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MUL,
		PH_RND,
		PH_DIV1,
		PH_OFS,
		PH_DIV2,
		PH_DONE
	} axis_phase_t;

endpackage

// ===== rtl/ptam_ifs.sv =====
// ---------------------------------------------------------------------------
// Pen to absolute pointer mapper: channel interfaces
// Pen event input, pointer event output and register write channels.
// ---------------------------------------------------------------------------
interface ptam_pen_if;
	logic                                 valid;
	logic                                 ready;
	logic        [ptam_pkg::OP_W-1:0]    operation;
	logic signed [ptam_pkg::COORD_W-1:0] pen_x;
	logic signed [ptam_pkg::COORD_W-1:0] pen_y;

	modport source (output valid, operation, pen_x, pen_y, input ready);
	modport sink   (input valid, operation, pen_x, pen_y, output ready);
endinterface

interface ptam_ptr_if;
	logic                          valid;
	logic                          ready;
	logic [ptam_pkg::KIND_W-1:0]  event_kind;
	logic [ptam_pkg::ABS_W-1:0]   abs_x;
	logic [ptam_pkg::ABS_W-1:0]   abs_y;

	modport source (output valid, event_kind, abs_x, abs_y, input ready);
	modport sink   (input valid, event_kind, abs_x, abs_y, output ready);
endinterface

interface ptam_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ptam_pkg::IDX_W-1:0]   index;
	logic [ptam_pkg::SIZE_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ptam_axis.sv =====
// ---------------------------------------------------------------------------
// Pen to absolute pointer mapper: axis datapath
// Clamp, then bit-serial scale (shift-add multiply, restoring divide), offset and
// normalize for one coordinate axis.
// ---------------------------------------------------------------------------
module ptam_axis #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [ptam_pkg::COORD_W-1:0] coord,
	input  logic        [ptam_pkg::SIZE_W-1:0]  tsize,
	input  logic        [ptam_pkg::SIZE_W-1:0]  off,
	input  logic        [ptam_pkg::SIZE_W-1:0]  msize,
	input  logic        [ptam_pkg::SIZE_W-1:0]  dsize,
	output logic                                 done,
	output logic        [ptam_pkg::ABS_W-1:0]   result
);

	localparam int SW       = ptam_pkg::SIZE_W;
	localparam int ITER_MAX = (COORD_BITS > SW) ? COORD_BITS : SW;
	localparam int CNT_W    = $clog2(ITER_MAX);
	localparam logic [CNT_W-1:0] SW_LAST  = CNT_W'(SW - 1);
	localparam logic [CNT_W-1:0] CB_LAST  = CNT_W'(COORD_BITS - 1);

	ptam_pkg::axis_phase_t phase_q, phase_d;
	logic [CNT_W-1:0]      cnt_q;

	logic [SW-1:0]         hi_q;
	logic [SW-1:0]         lo_q;
	logic [COORD_BITS-1:0] nq_q;
	logic                  sat_q;

	logic [SW-1:0]     mcand, den, tmax, cc;
	logic              over;
	logic [SW:0]       mul_sum;
	logic [2*SW-1:0]   rnd_sum;
	logic [SW:0]       d1_trial, d1_diff, d2_trial, d2_diff, pix;
	logic              d1_ge, d2_ge, sat;
	logic [ITER_MAX-1:0] nq_ext;

	always_comb begin
		mcand    = msize - SW'(1);
		den      = (tsize > SW'(1)) ? (tsize - SW'(1)) : SW'(1);
		tmax     = tsize - SW'(1);
		over     = {1'b0, coord[SW-2:0]} > tmax;
		if (coord[SW-1]) begin
			cc = '0;
		end else if (over) begin
			cc = tmax;
		end else begin
			cc = {1'b0, coord[SW-2:0]};
		end
		mul_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand} : '0);
		rnd_sum  = {hi_q, lo_q} + {{(SW+1){1'b0}}, den[SW-1:1]};
		d1_trial = {hi_q, lo_q[SW-1]};
		d1_ge    = d1_trial >= {1'b0, den};
		d1_diff  = d1_trial - {1'b0, den};
		pix      = {1'b0, off} + {1'b0, lo_q};
		sat      = pix >= {1'b0, dsize};
		d2_trial = {hi_q, nq_q[COORD_BITS-1]};
		d2_ge    = d2_trial >= {1'b0, dsize};
		d2_diff  = d2_trial - {1'b0, dsize};
		nq_ext   = ITER_MAX'(nq_q);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			ptam_pkg::PH_IDLE: if (start) phase_d = ptam_pkg::PH_MUL;
			ptam_pkg::PH_MUL:  if (cnt_q == '0) phase_d = ptam_pkg::PH_RND;
			ptam_pkg::PH_RND:  phase_d = ptam_pkg::PH_DIV1;
			ptam_pkg::PH_DIV1: if (cnt_q == '0) phase_d = ptam_pkg::PH_OFS;
			ptam_pkg::PH_OFS:  phase_d = ptam_pkg::PH_DIV2;
			ptam_pkg::PH_DIV2: if (cnt_q == '0) phase_d = ptam_pkg::PH_DONE;
			ptam_pkg::PH_DONE: phase_d = ptam_pkg::PH_IDLE;
			default:           phase_d = ptam_pkg::PH_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done   = (phase_q == ptam_pkg::PH_DONE);
		result = nq_ext[ptam_pkg::ABS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ptam_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			case (phase_q)
				ptam_pkg::PH_IDLE: cnt_q <= SW_LAST;
				ptam_pkg::PH_RND:  cnt_q <= SW_LAST;
				ptam_pkg::PH_OFS:  cnt_q <= CB_LAST;
				ptam_pkg::PH_MUL,
				ptam_pkg::PH_DIV1,
				ptam_pkg::PH_DIV2: cnt_q <= cnt_q - CNT_W'(1);
				default:           cnt_q <= cnt_q;
			endcase
		end
	end

	// a saturated axis still runs the normalize steps so both axes finish together
	always_ff @(posedge clk) begin
		case (phase_q)
			ptam_pkg::PH_IDLE: begin
				if (start) begin
					hi_q <= '0;
					lo_q <= cc;
				end
			end
			ptam_pkg::PH_MUL: begin
				hi_q <= mul_sum[SW:1];
				lo_q <= {mul_sum[0], lo_q[SW-1:1]};
			end
			ptam_pkg::PH_RND: begin
				hi_q <= rnd_sum[2*SW-1:SW];
				lo_q <= rnd_sum[SW-1:0];
			end
			ptam_pkg::PH_DIV1: begin
				hi_q <= d1_ge ? d1_diff[SW-1:0] : d1_trial[SW-1:0];
				lo_q <= {lo_q[SW-2:0], d1_ge};
			end
			ptam_pkg::PH_OFS: begin
				sat_q <= sat;
				if (sat) begin
					nq_q <= '1;
				end else begin
					hi_q <= pix[SW-1:0];
					nq_q <= {1'b1, {(COORD_BITS-1){1'b0}}};
				end
			end
			ptam_pkg::PH_DIV2: begin
				if (!sat_q) begin
					hi_q <= d2_ge ? d2_diff[SW-1:0] : d2_trial[SW-1:0];
					nq_q <= {nq_q[COORD_BITS-2:0], d2_ge};
				end
			end
			default: begin
				hi_q <= hi_q;
			end
		endcase
	end

endmodule

// ===== rtl/pen_to_absolute_pointer_mapper_core.sv =====
// ---------------------------------------------------------------------------
// Pen to absolute pointer mapper core
// Tracks pen range and button state and emits absolute pointer items.
// ---------------------------------------------------------------------------
// Usage:
//   pen  : pen event items in (operation, pen_x, pen_y), valid/ready.
//   ptr  : pointer event items out (event_kind, abs_x, abs_y), valid/ready.
//   cfg  : register writes (index, data), always ready; write only when idle.
// An item with no result leaves the core idle. A release goes to the done
// state and is loaded into the output register once it is free. A move or
// press runs both axes in parallel through a bit-serial datapath: 16 multiply
// steps, 16 divide steps and COORD_BITS normalize steps. When the axes finish,
// the control moves to the done state and loads the result into the output
// register; the next item is taken once the control is back in idle.
// One item is in flight at a time; the next is taken while a result still
// waits in the output register. If the receiver stalls, a finished result
// holds the datapath until the output register frees up.
// Reset clears range and button state and loads the default geometry
// (1920x1080 tablet, monitor and desktop, zero offsets).
// ---------------------------------------------------------------------------
`include "pen_to_absolute_pointer_mapper_core_defines.svh"

module pen_to_absolute_pointer_mapper_core #(
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	ptam_pen_if.sink         pen,
	ptam_ptr_if.source       ptr,
	ptam_cfg_if.sink         cfg
);

	logic [ptam_pkg::SIZE_W-1:0] cfg_q [ptam_pkg::NUM_REGS];

	ptam_pkg::ctl_state_t state_q, state_d;
	logic in_range_q, button_down_q;
	logic in_range_d, button_down_d;
	logic [ptam_pkg::KIND_W-1:0] kind_q, kind_d;

	logic enabled, take, has_res, is_rel;
	logic pen_ready, axis_start, load;
	logic x_done, y_done;
	logic [ptam_pkg::ABS_W-1:0] x_res, y_res;

	logic                         out_valid_q;
	logic [ptam_pkg::KIND_W-1:0]  out_kind_q;
	logic [ptam_pkg::ABS_W-1:0]   out_x_q, out_y_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptam_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= ptam_pkg::CFG_RESET[i];
			end
		end else if (cfg.valid) begin
			cfg_q[cfg.index] <= cfg.data;
		end
	end

	// item decode
	always_comb begin
		enabled = (cfg_q[ptam_pkg::REG_TABLET_WIDTH]   != '0) &&
		          (cfg_q[ptam_pkg::REG_TABLET_HEIGHT]  != '0) &&
		          (cfg_q[ptam_pkg::REG_MON_WIDTH]      != '0) &&
		          (cfg_q[ptam_pkg::REG_MON_HEIGHT]     != '0) &&
		          (cfg_q[ptam_pkg::REG_DESKTOP_WIDTH]  != '0) &&
		          (cfg_q[ptam_pkg::REG_DESKTOP_HEIGHT] != '0);
		has_res       = 1'b0;
		is_rel        = 1'b0;
		kind_d        = ptam_pkg::KIND_MOVE;
		in_range_d    = in_range_q;
		button_down_d = button_down_q;
		if (enabled) begin
			case (pen.operation)
				ptam_pkg::OP_PROX_IN: begin
					in_range_d = 1'b1;
				end
				ptam_pkg::OP_MOVE: begin
					has_res = in_range_q;
				end
				ptam_pkg::OP_DOWN: begin
					if (in_range_q && !button_down_q) begin
						has_res       = 1'b1;
						kind_d        = ptam_pkg::KIND_PRESS;
						button_down_d = 1'b1;
					end
				end
				ptam_pkg::OP_UP: begin
					has_res       = button_down_q;
					is_rel        = 1'b1;
					kind_d        = ptam_pkg::KIND_RELEASE;
					button_down_d = 1'b0;
				end
				ptam_pkg::OP_PROX_OUT: begin
					has_res       = button_down_q;
					is_rel        = 1'b1;
					kind_d        = ptam_pkg::KIND_RELEASE;
					button_down_d = 1'b0;
					in_range_d    = 1'b0;
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end
	end

	assign take = pen.valid && pen_ready;

	// control next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptam_pkg::CTL_IDLE: begin
				if (take && has_res) begin
					state_d = is_rel ? ptam_pkg::CTL_DONE : ptam_pkg::CTL_CALC;
				end
			end
			ptam_pkg::CTL_CALC: if (x_done) state_d = ptam_pkg::CTL_DONE;
			ptam_pkg::CTL_DONE: if (load) state_d = ptam_pkg::CTL_IDLE;
			default:            state_d = ptam_pkg::CTL_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pen_ready  = (state_q == ptam_pkg::CTL_IDLE);
		axis_start = take && has_res && !is_rel;
		load       = (state_q == ptam_pkg::CTL_DONE) && (!out_valid_q || ptr.ready);
	end

	assign pen.ready = pen_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ptam_pkg::CTL_IDLE;
			in_range_q    <= 1'b0;
			button_down_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				in_range_q    <= in_range_d;
				button_down_q <= button_down_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (ptr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= kind_d;
		end
		if (load) begin
			out_kind_q <= kind_q;
			if (kind_q == ptam_pkg::KIND_RELEASE) begin
				out_x_q <= '0;
				out_y_q <= '0;
			end else begin
				out_x_q <= x_res;
				out_y_q <= y_res;
			end
		end
	end

	assign ptr.valid      = out_valid_q;
	assign ptr.event_kind = out_kind_q;
	assign ptr.abs_x      = out_x_q;
	assign ptr.abs_y      = out_y_q;

	ptam_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (axis_start),
		.coord  (pen.pen_x),
		.tsize  (cfg_q[ptam_pkg::REG_TABLET_WIDTH]),
		.off    (cfg_q[ptam_pkg::REG_MON_X_OFFSET]),
		.msize  (cfg_q[ptam_pkg::REG_MON_WIDTH]),
		.dsize  (cfg_q[ptam_pkg::REG_DESKTOP_WIDTH]),
		.done   (x_done),
		.result (x_res)
	);

	ptam_axis #(
		.COORD_BITS (COORD_BITS)
	) u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (axis_start),
		.coord  (pen.pen_y),
		.tsize  (cfg_q[ptam_pkg::REG_TABLET_HEIGHT]),
		.off    (cfg_q[ptam_pkg::REG_MON_Y_OFFSET]),
		.msize  (cfg_q[ptam_pkg::REG_MON_HEIGHT]),
		.dsize  (cfg_q[ptam_pkg::REG_DESKTOP_HEIGHT]),
		.done   (y_done),
		.result (y_res)
	);

	`PTAM_ASSERT_IMPL(a_axes_in_step, clk, arst_n, 1'b1, x_done == y_done)
	`PTAM_ASSERT_IMPL(a_done_in_calc, clk, arst_n, x_done, state_q == ptam_pkg::CTL_CALC)
	`PTAM_ASSERT_IMPL(a_button_in_range, clk, arst_n, button_down_q, in_range_q)
	`PTAM_ASSERT_IMPL(a_release_zero, clk, arst_n,
		ptr.valid && (ptr.event_kind == ptam_pkg::KIND_RELEASE),
		(ptr.abs_x == '0) && (ptr.abs_y == '0))
	`PTAM_ASSERT_NEXT(a_load_shows, clk, arst_n, load, ptr.valid)

endmodule
